FILE: rtl/sqca_pkg.sv
// Shared types and constants for the quad corner angular sort.
// Used by sqca_rank and by the top level sort_quad_corners_by_angle.
package sqca_pkg;

    // Four corners per quad, two coordinates per corner
    localparam int NUM_CORNERS       = 4;
    localparam int FIELDS_PER_CORNER = 2;
    // Result coordinates never carry more than this many bits
    localparam int OUT_FIELD_BITS    = 16;

    // Position of a corner in the sorted order
    typedef logic [1:0] rank_t;

    // Half-plane class of an offset, numbered in ascending angle order
    typedef enum logic [1:0] {
        CLS_LOWER = 2'd0,   // dy < 0: angle between -pi and 0
        CLS_ZERO  = 2'd1,   // dy = 0, dx >= 0: angle 0 (also the centroid itself)
        CLS_UPPER = 2'd2,   // dy > 0: angle between 0 and pi
        CLS_PI    = 2'd3    // dy = 0, dx < 0: angle pi
    } corner_class_t;

endpackage

FILE: rtl/sqca_rank.sv
// Rank unit: angle of each corner about the centroid, pairwise compare, stable rank.
// Purely combinational; depends on sqca_pkg.
module sqca_rank #(
    parameter int COORD_BITS = 16
) (
    input  logic [sqca_pkg::NUM_CORNERS-1:0][COORD_BITS-1:0] px,
    input  logic [sqca_pkg::NUM_CORNERS-1:0][COORD_BITS-1:0] py,
    output sqca_pkg::rank_t [sqca_pkg::NUM_CORNERS-1:0]      rank
);

    localparam int N     = sqca_pkg::NUM_CORNERS;
    localparam int SUM_W = COORD_BITS + 2;
    localparam int D_W   = COORD_BITS + 3;
    localparam int CR_W  = 2 * D_W + 1;

    logic [SUM_W-1:0]                 sx;
    logic [SUM_W-1:0]                 sy;
    logic signed [D_W-1:0]            dx [N];
    logic signed [D_W-1:0]            dy [N];
    sqca_pkg::corner_class_t          cls [N];
    // lt[a][b]: corner a has a strictly smaller angle than corner b
    logic [N-1:0][N-1:0]              lt;

    // Sum the coordinates
    always_comb
    begin
        sx = '0;
        sy = '0;
        for (int i = 0; i < N; i++)
        begin
            sx = sx + SUM_W'(px[i]);
            sy = sy + SUM_W'(py[i]);
        end
    end

    // Offsets scaled by four (4*p - sum) and their half-plane class
    always_comb
    begin
        for (int i = 0; i < N; i++)
        begin
            dx[i] = $signed({1'b0, px[i], 2'b00}) - $signed({1'b0, sx});
            dy[i] = $signed({1'b0, py[i], 2'b00}) - $signed({1'b0, sy});
            if (dy[i] < 0)
                cls[i] = sqca_pkg::CLS_LOWER;
            else if (dy[i] == 0 && dx[i] >= 0)
                cls[i] = sqca_pkg::CLS_ZERO;
            else if (dy[i] > 0)
                cls[i] = sqca_pkg::CLS_UPPER;
            else
                cls[i] = sqca_pkg::CLS_PI;
        end
    end

    // Compare each pair once; the cross product's sign serves both directions
    for (genvar gi = 0; gi < N; gi++)
    begin : g_row
        for (genvar gj = 0; gj < N; gj++)
        begin : g_col
            if (gi == gj)
            begin : g_diag
                assign lt[gi][gj] = 1'b0;
            end
            else if (gi < gj)
            begin : g_pair
                logic signed [CR_W-1:0] cr;
                logic                   open_half;

                assign cr = (CR_W'(dx[gi]) * CR_W'(dy[gj])) - (CR_W'(dy[gi]) * CR_W'(dx[gj]));
                assign open_half = (cls[gi] == cls[gj])
                                && (cls[gi] == sqca_pkg::CLS_LOWER
                                    || cls[gi] == sqca_pkg::CLS_UPPER);
                assign lt[gi][gj] = (cls[gi] < cls[gj])
                                 || (open_half && !cr[CR_W-1] && (cr != '0));
                assign lt[gj][gi] = (cls[gj] < cls[gi])
                                 || (open_half && cr[CR_W-1]);
            end
        end
    end

    // Stable rank: count smaller corners, plus earlier corners of equal angle
    always_comb
    begin
        for (int i = 0; i < N; i++)
        begin
            rank[i] = '0;
            for (int j = 0; j < N; j++)
            begin
                if (j != i)
                begin
                    if (lt[j][i])
                        rank[i] = rank[i] + sqca_pkg::rank_t'(1);
                    else if (j < i && !lt[i][j])
                        rank[i] = rank[i] + sqca_pkg::rank_t'(1);
                end
            end
        end
    end

endmodule

FILE: rtl/sort_quad_corners_by_angle.sv
// Top level of the quad corner angular sort: input register, rank unit, result register.
// Depends on sqca_pkg and sqca_rank.
//
//  channel   | dir | fields (tdata, lowest bits first)                        | words
//  s_axis    | in  | corner0_x corner0_y corner1_x .. corner3_y, COORD_BITS each | one quad
//  m_axis    | out | sorted0_x sorted0_y sorted1_x .. sorted3_y, COORD_BITS each | one quad
//
// One word in, one word out; a new word is taken every cycle unless a stall on m_axis backs up both registers.
// A word passes through the input register, then rank/select logic into the result register.
// The critical path is the pairwise cross-product multiply and compare in sqca_rank.
// Reset clears the valid flags only; data registers are not reset.
// A stall on m_axis holds the result; the input register still fills while the result waits.
module sort_quad_corners_by_angle #(
    parameter int COORD_BITS = 16
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   s_tvalid,
    output logic                                   s_tready,
    // corner0_x, corner0_y, corner1_x, corner1_y, corner2_x, corner2_y, corner3_x, corner3_y
    input  logic [((8 * COORD_BITS + 7) / 8) * 8 - 1:0] s_tdata,
    output logic                                   m_tvalid,
    input  logic                                   m_tready,
    // sorted0_x, sorted0_y, sorted1_x, sorted1_y, sorted2_x, sorted2_y, sorted3_x, sorted3_y
    output logic [((8 * COORD_BITS + 7) / 8) * 8 - 1:0] m_tdata
);

    localparam int N         = sqca_pkg::NUM_CORNERS;
    localparam int FPC       = sqca_pkg::FIELDS_PER_CORNER;
    localparam int TDATA_W   = ((8 * COORD_BITS + 7) / 8) * 8;
    localparam int KEEP_BITS = (COORD_BITS < sqca_pkg::OUT_FIELD_BITS)
                               ? COORD_BITS : sqca_pkg::OUT_FIELD_BITS;
    localparam logic [COORD_BITS-1:0] KEEP_MASK =
        {COORD_BITS{1'b1}} >> (COORD_BITS - KEEP_BITS);

    logic                                  in_valid_reg;
    logic [TDATA_W-1:0]                    in_data_reg;
    logic                                  out_valid_reg;
    logic [TDATA_W-1:0]                    out_data_reg;
    logic [TDATA_W-1:0]                    out_data_next;
    logic                                  advance;
    logic [N-1:0][COORD_BITS-1:0]          px;
    logic [N-1:0][COORD_BITS-1:0]          py;
    sqca_pkg::rank_t [N-1:0]               rank;

    // Move forward whenever the result register is free or being drained
    assign advance  = !out_valid_reg || m_tready;
    assign s_tready = !in_valid_reg || advance;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    // Unpack the registered word into corners
    always_comb
    begin
        for (int i = 0; i < N; i++)
        begin
            px[i] = in_data_reg[(FPC * i) * COORD_BITS +: COORD_BITS];
            py[i] = in_data_reg[(FPC * i + 1) * COORD_BITS +: COORD_BITS];
        end
    end

    sqca_rank #(
        .COORD_BITS (COORD_BITS)
    ) u_rank (
        .px   (px),
        .py   (py),
        .rank (rank)
    );

    // Route each corner to the slot given by its rank (ranks form a permutation)
    always_comb
    begin
        out_data_next = '0;
        for (int k = 0; k < N; k++)
        begin
            for (int i = 0; i < N; i++)
            begin
                if (rank[i] == sqca_pkg::rank_t'(k))
                begin
                    out_data_next[(FPC * k) * COORD_BITS +: COORD_BITS] =
                        out_data_next[(FPC * k) * COORD_BITS +: COORD_BITS]
                        | (px[i] & KEEP_MASK);
                    out_data_next[(FPC * k + 1) * COORD_BITS +: COORD_BITS] =
                        out_data_next[(FPC * k + 1) * COORD_BITS +: COORD_BITS]
                        | (py[i] & KEEP_MASK);
                end
            end
        end
    end

    // Valid flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s_tready)
                in_valid_reg <= s_tvalid;
            if (advance)
                out_valid_reg <= in_valid_reg;
        end
    end

    // Data registers: capture on accept, load result on advance
    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
            in_data_reg <= s_tdata;
        if (advance && in_valid_reg)
            out_data_reg <= out_data_next;
    end

endmodule

FILE: rtl/sqca_checker.sv
// Port-level checks for sort_quad_corners_by_angle, attached by bind.
// Depends only on the top level's ports.
module sqca_checker #(
    parameter int TDATA_W = 128
) (
    input logic               clk,
    input logic               rst_n,
    input logic               s_tvalid,
    input logic               s_tready,
    input logic [TDATA_W-1:0] s_tdata,
    input logic               m_tvalid,
    input logic               m_tready,
    input logic [TDATA_W-1:0] m_tdata
);

    // Hold a stalled result word
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result word changed while stalled");

    // Show no valid output during reset
    a_reset_empty: assert property (@(posedge clk)
        !rst_n |-> !m_tvalid)
        else $error("result valid during reset");

    // Accept input whenever the result register is empty
    a_ready_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !m_tvalid |-> s_tready)
        else $error("input stalled with empty result register");

    // A word taken with a free path reaches the output through the input and result registers
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && !m_tvalid ##1 m_tready |=> m_tvalid)
        else $error("accepted word did not reach the output");

endmodule

bind sort_quad_corners_by_angle sqca_checker #(
    .TDATA_W (TDATA_W)
) u_sqca_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
